// File: sv/epm_pkg.sv
// Shared constants, codes and controller/datapath types of the exact pattern matcher.
`default_nettype none
package epm_pkg;

   localparam int MAX_PATTERN = 64;
   localparam int SYM_W       = 7;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

   localparam logic [DATA_W-1:0] SAT_VALUE = {DATA_W{1'b1}};

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_TEXT  = 2'd1,
      OP_END   = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic {
      KIND_MATCH   = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic do_load;
      logic do_text;
      logic do_end;
      logic do_clear;
      logic rd_issue;
      logic step;
      logic hit;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic window_ok;
      logic char_eq;
      logic last_char;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

// File: sv/epm_req_if.sv
// Request channel interface: opcode and symbol with valid/ready.
`default_nettype none
interface epm_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  opcode;
   logic [epm_pkg::SYM_W-1:0]   symbol;

   modport source (output valid, output opcode, output symbol, input ready);
   modport sink   (input valid, input opcode, input symbol, output ready);
endinterface
`default_nettype wire

// File: sv/epm_rsp_if.sv
// Response channel interface: match report or end-of-text summary with valid/ready.
`default_nettype none
interface epm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [epm_pkg::DATA_W-1:0]   match_index;
   logic [epm_pkg::DATA_W-1:0]   match_total;

   modport source (output valid, output kind, output match_index, output match_total,
                   input ready);
   modport sink   (input valid, input kind, input match_index, input match_total,
                   output ready);
endinterface
`default_nettype wire

// File: sv/epm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module epm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output      logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: sv/epm_ctrl.sv
// Controller state machine: sequences load, text compare, summary and clear beats.
`default_nettype none
module epm_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [1:0]       req_opcode,
   input  wire epm_pkg::stat_type status,
   output      logic             req_ready,
   output      epm_pkg::cmd_type cmd
);

   epm_pkg::state_type state_ff, state_in;
   logic               accept;

   assign accept = (state_ff == epm_pkg::ST_IDLE) && req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= epm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         epm_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (epm_pkg::op_type'(req_opcode))
                  epm_pkg::OP_TEXT: begin
                     if (status.window_ok) state_in = epm_pkg::ST_READ;
                  end
                  epm_pkg::OP_END:   state_in = epm_pkg::ST_EMIT;
                  epm_pkg::OP_LOAD:  state_in = epm_pkg::ST_IDLE;
                  epm_pkg::OP_CLEAR: state_in = epm_pkg::ST_IDLE;
                  default:           state_in = epm_pkg::ST_IDLE;
               endcase
            end
         end
         epm_pkg::ST_READ: state_in = epm_pkg::ST_CHECK;
         epm_pkg::ST_CHECK: begin
            if (!status.char_eq) begin
               state_in = epm_pkg::ST_IDLE;
            end else if (status.last_char) begin
               state_in = epm_pkg::ST_EMIT;
            end else begin
               state_in = epm_pkg::ST_READ;
            end
         end
         epm_pkg::ST_EMIT: begin
            if (status.out_free) state_in = epm_pkg::ST_IDLE;
         end
         default: state_in = epm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == epm_pkg::ST_IDLE);
      cmd          = '0;
      cmd.do_load  = accept && (req_opcode == epm_pkg::OP_LOAD);
      cmd.do_text  = accept && (req_opcode == epm_pkg::OP_TEXT);
      cmd.do_end   = accept && (req_opcode == epm_pkg::OP_END);
      cmd.do_clear = accept && (req_opcode == epm_pkg::OP_CLEAR);
      cmd.rd_issue = (state_ff == epm_pkg::ST_READ);
      cmd.step     = (state_ff == epm_pkg::ST_CHECK) && status.char_eq && !status.last_char;
      cmd.hit      = (state_ff == epm_pkg::ST_CHECK) && status.char_eq && status.last_char;
      cmd.emit     = (state_ff == epm_pkg::ST_EMIT) && status.out_free;
   end

endmodule
`default_nettype wire

// File: sv/epm_datapath.sv
// Datapath: pattern and history RAMs, counters, compare and the response register.
`default_nettype none
module epm_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire epm_pkg::cmd_type              cmd,
   input  wire logic [epm_pkg::SYM_W-1:0]     req_symbol,
   input  wire logic                          rsp_ready,
   output      epm_pkg::stat_type             status,
   output      logic                          rsp_valid,
   output      logic                          rsp_kind,
   output      logic [epm_pkg::DATA_W-1:0]    rsp_match_index,
   output      logic [epm_pkg::DATA_W-1:0]    rsp_match_total
);

   localparam int AW = epm_pkg::ADDR_W;
   localparam int LW = epm_pkg::LEN_W;
   localparam int DW = epm_pkg::DATA_W;
   localparam logic [LW-1:0] LEN_MAX  = LW'(epm_pkg::MAX_PATTERN);
   localparam logic [AW-1:0] ADDR_TOP = AW'(epm_pkg::MAX_PATTERN - 1);

   logic [LW-1:0] plen_ff, plen_in;
   logic [LW-1:0] fill_ff, fill_in;
   logic [AW-1:0] wr_ff, wr_in;
   logic [DW-1:0] pos_ff, pos_in;
   logic [DW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] ha_ff, ha_in;
   logic [AW-1:0] pa_ff, pa_in;
   logic [LW-1:0] left_ff, left_in;
   logic          stage_kind_ff, stage_kind_in;
   logic [DW-1:0] stage_idx_ff, stage_idx_in;
   logic [DW-1:0] stage_total_ff, stage_total_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff, rsp_kind_in;
   logic [DW-1:0] rsp_idx_ff, rsp_idx_in;
   logic [DW-1:0] rsp_total_ff, rsp_total_in;

   logic [LW-1:0] fill_next;
   logic [DW-1:0] cnt_next;
   logic [epm_pkg::SYM_W-1:0] pat_rd, hist_rd;
   logic          pat_wr_en;

   assign pat_wr_en = cmd.do_load && (plen_ff < LEN_MAX);
   assign fill_next = (fill_ff == LEN_MAX) ? fill_ff : fill_ff + LW'(1);
   assign cnt_next  = (cnt_ff == epm_pkg::SAT_VALUE) ? cnt_ff : cnt_ff + DW'(1);

   epm_ram #(.WIDTH(epm_pkg::SYM_W), .DEPTH(epm_pkg::MAX_PATTERN)) u_pattern_ram (
      .clock   (clock),
      .wr_en   (pat_wr_en),
      .wr_addr (plen_ff[AW-1:0]),
      .wr_data (req_symbol),
      .rd_en   (cmd.rd_issue),
      .rd_addr (pa_ff),
      .rd_data (pat_rd)
   );

   // History is a circular buffer; wr_ff points at the slot for the next character.
   epm_ram #(.WIDTH(epm_pkg::SYM_W), .DEPTH(epm_pkg::MAX_PATTERN)) u_history_ram (
      .clock   (clock),
      .wr_en   (cmd.do_text),
      .wr_addr (wr_ff),
      .wr_data (req_symbol),
      .rd_en   (cmd.rd_issue),
      .rd_addr (ha_ff),
      .rd_data (hist_rd)
   );

   always_comb begin
      status.window_ok = (plen_ff != '0) && (fill_next >= plen_ff);
      status.char_eq   = (hist_rd == pat_rd);
      status.last_char = (left_ff == LW'(1));
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      plen_in        = plen_ff;
      fill_in        = fill_ff;
      wr_in          = wr_ff;
      pos_in         = pos_ff;
      cnt_in         = cnt_ff;
      ha_in          = ha_ff;
      pa_in          = pa_ff;
      left_in        = left_ff;
      stage_kind_in  = stage_kind_ff;
      stage_idx_in   = stage_idx_ff;
      stage_total_in = stage_total_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_total_in   = rsp_total_ff;

      if (pat_wr_en) begin
         plen_in = plen_ff + LW'(1);
      end

      if (cmd.do_text) begin
         fill_in      = fill_next;
         wr_in        = (wr_ff == ADDR_TOP) ? '0 : wr_ff + AW'(1);
         pos_in       = (pos_ff == epm_pkg::SAT_VALUE) ? pos_ff : pos_ff + DW'(1);
         // Walk back from the newest character and from the pattern's last one.
         ha_in        = wr_ff;
         pa_in        = AW'(plen_ff - LW'(1));
         left_in      = plen_ff;
         stage_idx_in = pos_ff - (DW'(plen_ff) - DW'(1));
      end

      if (cmd.step) begin
         ha_in   = (ha_ff == '0) ? ADDR_TOP : ha_ff - AW'(1);
         pa_in   = pa_ff - AW'(1);
         left_in = left_ff - LW'(1);
      end

      if (cmd.hit) begin
         cnt_in         = cnt_next;
         stage_kind_in  = epm_pkg::KIND_MATCH;
         stage_total_in = cnt_next;
      end

      if (cmd.do_end) begin
         stage_kind_in  = epm_pkg::KIND_SUMMARY;
         stage_idx_in   = '0;
         stage_total_in = cnt_ff;
      end

      if (cmd.do_end || cmd.do_clear) begin
         fill_in = '0;
         pos_in  = '0;
         cnt_in  = '0;
      end

      if (cmd.do_clear) begin
         plen_in = '0;
      end

      // Hold the beat until taken; load a new one only into a free slot.
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = stage_kind_ff;
         rsp_idx_in   = stage_idx_ff;
         rsp_total_in = stage_total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff      <= '0;
         fill_ff      <= '0;
         wr_ff        <= '0;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         plen_ff      <= plen_in;
         fill_ff      <= fill_in;
         wr_ff        <= wr_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ha_ff          <= ha_in;
      pa_ff          <= pa_in;
      stage_kind_ff  <= stage_kind_in;
      stage_idx_ff   <= stage_idx_in;
      stage_total_ff <= stage_total_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_total_ff   <= rsp_total_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_match_index = rsp_idx_ff;
   assign rsp_match_total = rsp_total_ff;

endmodule
`default_nettype wire

// File: sv/exact_pattern_matcher_core.sv
// Load and clear beats finish on acceptance; so does a text beat while history holds fewer
// characters than the pattern length m, else it loops READ and CHECK: one history and one
// pattern RAM read per character, compare in the next cycle, stop at the first mismatch.
// A match and an end beat each add an emit state; emit stalls while the output register
// holds an untaken beat. One beat in flight at a time; the result is registered at emit.
// Sync active-high reset clears pattern length, fill, position, count and response valid.
`default_nettype none
module exact_pattern_matcher_core (
   input  wire logic   clock,
   input  wire logic   reset,
   epm_req_if.sink     req_chan,
   epm_rsp_if.source   rsp_chan
);

   epm_pkg::cmd_type  cmd;
   epm_pkg::stat_type status;

   epm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .status     (status),
      .req_ready  (req_chan.ready),
      .cmd        (cmd)
   );

   epm_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_symbol      (req_chan.symbol),
      .rsp_ready       (rsp_chan.ready),
      .status          (status),
      .rsp_valid       (rsp_chan.valid),
      .rsp_kind        (rsp_chan.kind),
      .rsp_match_index (rsp_chan.match_index),
      .rsp_match_total (rsp_chan.match_total)
   );

endmodule
`default_nettype wire
